// ----- design/multilevel_feedback_scheduler_assert.svh -----
// Assertion macros for the feedback scheduler.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define MFS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MFS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFS_ASSERT(label, clk, rst_n, prop, msg)
`define MFS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- design/mfs_pkg.sv -----
package mfs_pkg;

  localparam int unsigned TW        = 16;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM2 = 1'b1;

  localparam logic [TW-1:0] QUANTUM1_RST = 16'd4;
  localparam logic [TW-1:0] QUANTUM2_RST = 16'd8;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic RES_DONE   = 1'b0;
  localparam logic RES_REJECT = 1'b1;

  // larger than any remaining time, so the first scanned entry always wins
  localparam logic [TW:0] SCAN_BEST_INIT = {(TW+1){1'b1}};

  typedef enum logic [1:0] {
    ST_L1,
    ST_L2,
    ST_POOL
  } store_e;

  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_1,
    LVL_2,
    LVL_3
  } level_e;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TW-1:0]   arrival;
    logic [TW-1:0]   burst;
    logic [TW-1:0]   left;
  } job_t;

  typedef struct packed {
    logic   we;
    store_e wsel;
    store_e rsel;
  } mem_ctl_t;

endpackage

// ----- design/mfs_req_if.sv -----
interface mfs_req_if;
  import mfs_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [ID_W-1:0] job_id;
  logic [TW-1:0]   burst_length;

  modport source (output valid, req_type, job_id, burst_length, input ready);
  modport sink   (input valid, req_type, job_id, burst_length, output ready);
endinterface

// ----- design/mfs_res_if.sv -----
interface mfs_res_if;
  import mfs_pkg::*;
  logic            valid;
  logic            ready;
  logic            result_kind;
  logic [ID_W-1:0] done_id;
  logic [TW-1:0]   waiting_ticks;
  logic [TW-1:0]   turnaround_ticks;

  modport source (output valid, result_kind, done_id, waiting_ticks, turnaround_ticks,
                  input ready);
  modport sink   (input valid, result_kind, done_id, waiting_ticks, turnaround_ticks,
                  output ready);
endinterface

// ----- design/mfs_store.sv -----
module mfs_store #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                        clk_i,
  input  mfs_pkg::mem_ctl_t           ctl_i,
  input  logic [$clog2(MAX_JOBS)-1:0] widx_i,
  input  mfs_pkg::job_t               wdata_i,
  input  logic [$clog2(MAX_JOBS)-1:0] ridx_i,
  output mfs_pkg::job_t               rdata_o
);
  import mfs_pkg::*;

  localparam int unsigned IDXW  = $clog2(MAX_JOBS);
  localparam int unsigned DEPTH = 3 * MAX_JOBS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // three stores side by side: level 1, level 2, pool
  function automatic logic [AW-1:0] addr_of(store_e s, logic [IDXW-1:0] i);
    logic [AW-1:0] base;
    unique case (s)
      ST_L2:   base = AW'(MAX_JOBS);
      ST_POOL: base = AW'(2 * MAX_JOBS);
      default: base = '0;
    endcase
    return base + AW'(i);
  endfunction

  job_t mem [DEPTH];
  job_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_of(ctl_i.wsel, widx_i)] <= wdata_i;
    end
    rdata_q <= mem[addr_of(ctl_i.rsel, ridx_i)];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/multilevel_feedback_scheduler.sv -----
// Arrival: written to level 1 when accepted; a rejected arrival is reported via S_FINISH.
// Tick: levels 1 and 2 pass through S_TICK, a demotion and S_SEL where due, a data
// state and S_FINISH; a pool selection scans one pool entry per cycle through the
// single store read port, and a pool completion shifts each later entry down.
// Reset: all queues empty, quanta 4 and 8, time zero; store contents stay
// undefined and need no clearing pass.
module multilevel_feedback_scheduler #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mfs_req_if.sink                           req_i,
  mfs_res_if.source                         res_o,
  input  logic                              cfg_we_i,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mfs_pkg::TW-1:0]            cfg_wdata_i
);
  import mfs_pkg::*;

  `include "multilevel_feedback_scheduler_assert.svh"

  localparam int unsigned IDXW = $clog2(MAX_JOBS);
  localparam int unsigned CW   = $clog2(MAX_JOBS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_DEM_DATA,
    S_SEL,
    S_START_DATA,
    S_RUN_DATA,
    S_POOL_DATA,
    S_SCAN,
    S_SJF,
    S_SH_RD,
    S_SH_WR,
    S_FINISH
  } state_e;

  function automatic logic [IDXW-1:0] wrap_idx(logic [IDXW-1:0] h, logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(c);
    if (s >= (CW+1)'(MAX_JOBS)) s = s - (CW+1)'(MAX_JOBS);
    return s[IDXW-1:0];
  endfunction

  function automatic logic [IDXW-1:0] next_idx(logic [IDXW-1:0] h);
    return (h == IDXW'(MAX_JOBS - 1)) ? '0 : h + 1'b1;
  endfunction

  state_e          state_q, state_d;
  logic [TW-1:0]   time_q, time_d;
  logic [TW-1:0]   slice_q, slice_d;
  level_e          level_q, level_d;
  logic            dem_q, dem_d;
  logic [IDXW-1:0] chosen_q, chosen_d;
  logic [IDXW-1:0] head0_q, head0_d, head1_q, head1_d;
  logic [CW-1:0]   cnt0_q, cnt0_d, cnt1_q, cnt1_d, pcnt_q, pcnt_d;
  logic [IDXW-1:0] scan_q, scan_d;
  logic [TW:0]     best_q, best_d;
  job_t            best_job_q, best_job_d;
  logic [IDXW-1:0] sh_q, sh_d;
  logic            w_q, w_d;
  logic [TW-1:0]   q1_q, q1_d, q2_q, q2_d;
  logic            res_pend_q, res_pend_d;
  logic            res_kind_q, res_kind_d;
  logic [ID_W-1:0] res_id_q, res_id_d;
  logic [TW-1:0]   res_wait_q, res_wait_d, res_ta_q, res_ta_d;
  logic            out_valid_q, out_valid_d;
  logic            out_kind_q, out_kind_d;
  logic [ID_W-1:0] out_id_q, out_id_d;
  logic [TW-1:0]   out_wait_q, out_wait_d, out_ta_q, out_ta_d;

  mem_ctl_t        ctl;
  logic [IDXW-1:0] widx, ridx;
  job_t            wdata, rdata;

  job_t            cur_job, wb_job;
  logic [TW-1:0]   cur_left, rep_ta, rep_wait, qw;
  logic [CW+1:0]   total;
  logic [CW-1:0]   pcnt_m1, sh_p1;
  logic [IDXW-1:0] front_w, tail0, tail1;
  store_e          sel_w;

  mfs_store #(
    .MAX_JOBS (MAX_JOBS)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .widx_i  (widx),
    .wdata_i (wdata),
    .ridx_i  (ridx),
    .rdata_o (rdata)
  );

  assign cur_job  = (state_q == S_SJF) ? best_job_q : rdata;
  assign cur_left = cur_job.left - 1'b1;
  assign rep_ta   = time_q - cur_job.arrival;
  assign rep_wait = rep_ta - cur_job.burst;
  assign qw       = w_q ? q2_q : q1_q;
  assign front_w  = w_q ? head1_q : head0_q;
  assign sel_w    = w_q ? ST_L2 : ST_L1;
  assign tail0    = wrap_idx(head0_q, cnt0_q);
  assign tail1    = wrap_idx(head1_q, cnt1_q);
  assign total    = (CW+2)'(cnt0_q) + (CW+2)'(cnt1_q) + (CW+2)'(pcnt_q);
  assign pcnt_m1  = pcnt_q - 1'b1;
  assign sh_p1    = CW'(sh_q) + 1'b1;

  always_comb begin
    wb_job      = cur_job;
    wb_job.left = cur_left;
  end

  assign req_i.ready            = (state_q == S_IDLE);
  assign res_o.valid            = out_valid_q;
  assign res_o.result_kind      = out_kind_q;
  assign res_o.done_id          = out_id_q;
  assign res_o.waiting_ticks    = out_wait_q;
  assign res_o.turnaround_ticks = out_ta_q;

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    slice_d     = slice_q;
    level_d     = level_q;
    dem_d       = dem_q;
    chosen_d    = chosen_q;
    head0_d     = head0_q;
    head1_d     = head1_q;
    cnt0_d      = cnt0_q;
    cnt1_d      = cnt1_q;
    pcnt_d      = pcnt_q;
    scan_d      = scan_q;
    best_d      = best_q;
    best_job_d  = best_job_q;
    sh_d        = sh_q;
    w_d         = w_q;
    q1_d        = q1_q;
    q2_d        = q2_q;
    res_pend_d  = res_pend_q;
    res_kind_d  = res_kind_q;
    res_id_d    = res_id_q;
    res_wait_d  = res_wait_q;
    res_ta_d    = res_ta_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_wait_d  = out_wait_q;
    out_ta_d    = out_ta_q;
    ctl         = '{we: 1'b0, wsel: ST_L1, rsel: ST_L1};
    widx        = '0;
    ridx        = '0;
    wdata       = wb_job;

    if (cfg_we_i) begin
      if (cfg_idx_i == REG_QUANTUM1) q1_d = cfg_wdata_i;
      if (cfg_idx_i == REG_QUANTUM2) q2_d = cfg_wdata_i;
    end

    if (out_valid_q && res_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.req_type == REQ_TICK) begin
            time_d  = time_q + 1'b1;
            state_d = S_TICK;
          end else if (total >= (CW+2)'(MAX_JOBS)) begin
            res_pend_d = 1'b1;
            res_kind_d = RES_REJECT;
            res_id_d   = req_i.job_id;
            res_wait_d = '0;
            res_ta_d   = '0;
            state_d    = S_FINISH;
          end else begin
            ctl.we   = 1'b1;
            ctl.wsel = ST_L1;
            widx     = tail0;
            wdata    = '{id: req_i.job_id, arrival: time_q,
                         burst: req_i.burst_length, left: req_i.burst_length};
            cnt0_d   = cnt0_q + 1'b1;
          end
        end
      end

      S_TICK: begin
        if (slice_q != '0) begin
          slice_d = slice_q - 1'b1;
          if (slice_q == TW'(1)) dem_d = 1'b1;
          priority if ((level_q == LVL_1 && cnt0_q != '0) ||
                       (level_q == LVL_2 && cnt1_q != '0)) begin
            w_d      = (level_q == LVL_2);
            ctl.rsel = (level_q == LVL_2) ? ST_L2 : ST_L1;
            ridx     = (level_q == LVL_2) ? head1_q : head0_q;
            state_d  = S_RUN_DATA;
          end else if (level_q == LVL_3) begin
            dem_d = 1'b0;
            if (CW'(chosen_q) < pcnt_q) begin
              ctl.rsel = ST_POOL;
              ridx     = chosen_q;
              state_d  = S_POOL_DATA;
            end else begin
              state_d = S_FINISH;
            end
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          priority if (dem_q && level_q == LVL_1 && cnt0_q != '0) begin
            ctl.rsel = ST_L1;
            ridx     = head0_q;
            state_d  = S_DEM_DATA;
          end else if (dem_q && level_q == LVL_2 && cnt1_q != '0) begin
            ctl.rsel = ST_L2;
            ridx     = head1_q;
            state_d  = S_DEM_DATA;
          end else begin
            dem_d   = 1'b0;
            state_d = S_SEL;
          end
        end
      end

      S_DEM_DATA: begin
        ctl.we = 1'b1;
        wdata  = rdata;
        if (level_q == LVL_1) begin
          ctl.wsel = ST_L2;
          widx     = tail1;
          cnt1_d   = cnt1_q + 1'b1;
          head0_d  = next_idx(head0_q);
          cnt0_d   = cnt0_q - 1'b1;
        end else begin
          ctl.wsel = ST_POOL;
          widx     = pcnt_q[IDXW-1:0];
          pcnt_d   = pcnt_q + 1'b1;
          head1_d  = next_idx(head1_q);
          cnt1_d   = cnt1_q - 1'b1;
        end
        dem_d   = 1'b0;
        state_d = S_SEL;
      end

      S_SEL: begin
        priority if (cnt0_q != '0) begin
          w_d      = 1'b0;
          ctl.rsel = ST_L1;
          ridx     = head0_q;
          state_d  = S_START_DATA;
        end else if (cnt1_q != '0) begin
          w_d      = 1'b1;
          ctl.rsel = ST_L2;
          ridx     = head1_q;
          state_d  = S_START_DATA;
        end else if (pcnt_q != '0) begin
          // scan from the newest entry down so ties settle on the oldest
          scan_d   = pcnt_m1[IDXW-1:0];
          best_d   = SCAN_BEST_INIT;
          ctl.rsel = ST_POOL;
          ridx     = pcnt_m1[IDXW-1:0];
          state_d  = S_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_START_DATA, S_RUN_DATA: begin
        if (state_q == S_START_DATA) begin
          level_d = w_q ? LVL_2 : LVL_1;
          slice_d = qw - 1'b1;
        end
        if (cur_left == '0) begin
          slice_d    = qw;
          if (state_q == S_RUN_DATA) dem_d = 1'b0;
          res_pend_d = 1'b1;
          res_kind_d = RES_DONE;
          res_id_d   = cur_job.id;
          res_wait_d = rep_wait;
          res_ta_d   = rep_ta;
          if (w_q) begin
            head1_d = next_idx(head1_q);
            cnt1_d  = cnt1_q - 1'b1;
          end else begin
            head0_d = next_idx(head0_q);
            cnt0_d  = cnt0_q - 1'b1;
          end
        end else begin
          ctl.we   = 1'b1;
          ctl.wsel = sel_w;
          widx     = front_w;
        end
        state_d = S_FINISH;
      end

      S_POOL_DATA, S_SJF: begin
        if (state_q == S_SJF) begin
          level_d = LVL_3;
          slice_d = cur_left;
        end
        if (cur_left == '0) begin
          res_pend_d = 1'b1;
          res_kind_d = RES_DONE;
          res_id_d   = cur_job.id;
          res_wait_d = rep_wait;
          res_ta_d   = rep_ta;
          sh_d       = chosen_q;
          state_d    = S_SH_RD;
        end else begin
          ctl.we   = 1'b1;
          ctl.wsel = ST_POOL;
          widx     = chosen_q;
          state_d  = S_FINISH;
        end
      end

      S_SCAN: begin
        if ({1'b0, rdata.left} <= best_q) begin
          best_d     = {1'b0, rdata.left};
          chosen_d   = scan_q;
          best_job_d = rdata;
        end
        if (scan_q == '0) begin
          state_d = S_SJF;
        end else begin
          scan_d   = scan_q - 1'b1;
          ctl.rsel = ST_POOL;
          ridx     = scan_q - 1'b1;
        end
      end

      S_SH_RD: begin
        if (sh_p1 < pcnt_q) begin
          ctl.rsel = ST_POOL;
          ridx     = sh_p1[IDXW-1:0];
          state_d  = S_SH_WR;
        end else begin
          pcnt_d  = pcnt_q - 1'b1;
          state_d = S_FINISH;
        end
      end

      S_SH_WR: begin
        ctl.we   = 1'b1;
        ctl.wsel = ST_POOL;
        widx     = sh_q;
        wdata    = rdata;
        sh_d     = sh_p1[IDXW-1:0];
        state_d  = S_SH_RD;
      end

      S_FINISH: begin
        // a level that ran dry gives up the rest of its slice
        if (slice_q != '0 && ((level_q == LVL_1 && cnt0_q == '0) ||
                              (level_q == LVL_2 && cnt1_q == '0))) begin
          slice_d = '0;
        end
        if (!res_pend_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind_q;
          out_id_d    = res_id_q;
          out_wait_d  = res_wait_q;
          out_ta_d    = res_ta_q;
          res_pend_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      slice_q     <= '0;
      level_q     <= LVL_NONE;
      dem_q       <= 1'b0;
      chosen_q    <= '0;
      head0_q     <= '0;
      head1_q     <= '0;
      cnt0_q      <= '0;
      cnt1_q      <= '0;
      pcnt_q      <= '0;
      scan_q      <= '0;
      best_q      <= SCAN_BEST_INIT;
      best_job_q  <= '0;
      sh_q        <= '0;
      w_q         <= 1'b0;
      q1_q        <= QUANTUM1_RST;
      q2_q        <= QUANTUM2_RST;
      res_pend_q  <= 1'b0;
      res_kind_q  <= RES_DONE;
      res_id_q    <= '0;
      res_wait_q  <= '0;
      res_ta_q    <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= RES_DONE;
      out_id_q    <= '0;
      out_wait_q  <= '0;
      out_ta_q    <= '0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      slice_q     <= slice_d;
      level_q     <= level_d;
      dem_q       <= dem_d;
      chosen_q    <= chosen_d;
      head0_q     <= head0_d;
      head1_q     <= head1_d;
      cnt0_q      <= cnt0_d;
      cnt1_q      <= cnt1_d;
      pcnt_q      <= pcnt_d;
      scan_q      <= scan_d;
      best_q      <= best_d;
      best_job_q  <= best_job_d;
      sh_q        <= sh_d;
      w_q         <= w_d;
      q1_q        <= q1_d;
      q2_q        <= q2_d;
      res_pend_q  <= res_pend_d;
      res_kind_q  <= res_kind_d;
      res_id_q    <= res_id_d;
      res_wait_q  <= res_wait_d;
      res_ta_q    <= res_ta_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_id_q    <= out_id_d;
      out_wait_q  <= out_wait_d;
      out_ta_q    <= out_ta_d;
    end
  end

  `MFS_ASSERT(a_store_bound, clk_i, rst_ni, (32'(cnt0_q) + 32'(cnt1_q) + 32'(pcnt_q)) <= 32'(MAX_JOBS), "store occupancy above capacity")
  `MFS_ASSERT(a_l1_slice, clk_i, rst_ni, (state_q == S_IDLE && slice_q != '0 && level_q == LVL_1) |-> cnt0_q != '0, "level 1 slice open with empty FIFO")
  `MFS_ASSERT(a_pool_slot, clk_i, rst_ni, (state_q == S_IDLE && slice_q != '0 && level_q == LVL_3) |-> 32'(chosen_q) < 32'(pcnt_q), "running pool slot not valid")

endmodule
